/* hw/rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and transaction types of the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int SLOTS       = 256;
   localparam int SLOT_W      = 8;
   localparam int LINK_W      = 9;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 9;
   localparam int CHUNK_W     = 16;
   localparam int CHUNKS      = SLOTS / CHUNK_W;
   localparam int CHUNK_IDX_W = $clog2(CHUNKS);
   localparam int CHUNK_POS_W = $clog2(CHUNK_W);

   // null link: one past the last slot
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);

   localparam logic [1:0] REQ_INSERT       = 2'd0;
   localparam logic [1:0] REQ_REMOVE_VALUE = 2'd1;
   localparam logic [1:0] REQ_REMOVE_SLOT  = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [VALUE_W-1:0] value;
      logic [SLOT_W-1:0]  slot;
   } slt_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot_used;
      logic [COUNT_W-1:0] entry_count;
   } slt_rsp_type;

   typedef struct packed {
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] next;
   } link_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } store_rd_type;

   typedef struct packed {
      logic               value_en;
      logic               prev_en;
      logic               next_en;
      logic [SLOT_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
      logic [LINK_W-1:0]  prev;
      logic [LINK_W-1:0]  next;
   } store_wr_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      link_type           links;
   } store_q_type;

   typedef struct packed {
      logic              scan_start;
      logic              set_en;
      logic              clr_en;
      logic [SLOT_W-1:0] idx;
   } busy_ctrl_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic              probe_busy;
   } busy_stat_type;

endpackage

/* hw/rtl/slt_store.sv */
// ----------------------------------------------------------------------------
// slt_store
// Slot value memory and link memory, one read port and one write port each,
// registered read data. Link words take per-field write enables.
// ----------------------------------------------------------------------------
module slt_store (
   input  logic                 clock,
   input  slt_pkg::store_rd_type rd,
   input  slt_pkg::store_wr_type wr,
   output slt_pkg::store_q_type  q
);
   import slt_pkg::*;

   logic [VALUE_W-1:0] value_mem [SLOTS];
   link_type           link_mem  [SLOTS];
   store_q_type        q_ff;

   always_ff @(posedge clock) begin
      if (wr.value_en) begin
         value_mem[wr.addr] <= wr.value;
      end
      if (wr.prev_en) begin
         link_mem[wr.addr].prev <= wr.prev;
      end
      if (wr.next_en) begin
         link_mem[wr.addr].next <= wr.next;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         q_ff.value <= value_mem[rd.addr];
         q_ff.links <= link_mem[rd.addr];
      end
   end

   assign q = q_ff;

endmodule

/* hw/rtl/slt_busy.sv */
// ----------------------------------------------------------------------------
// slt_busy
// Slot busy flags with a lowest-free-slot search, one chunk of flags a cycle,
// and a single-slot probe.
// ----------------------------------------------------------------------------
module slt_busy (
   input  logic                  clock,
   input  logic                  reset,
   input  slt_pkg::busy_ctrl_type ctrl,
   output slt_pkg::busy_stat_type stat
);
   import slt_pkg::*;

   logic [SLOTS-1:0]       busy_ff, busy_in;
   logic                   scanning_ff, scanning_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic                   done_ff, done_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;

   logic [CHUNK_W-1:0]     free_word;
   logic                   free_any;
   logic [CHUNK_POS_W-1:0] free_pos;

   assign free_word = ~busy_ff[{chunk_ff, {CHUNK_POS_W{1'b0}}} +: CHUNK_W];
   assign free_any  = |free_word;

   // lowest set bit wins
   always_comb begin
      free_pos = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         if (free_word[i]) begin
            free_pos = CHUNK_POS_W'(i);
         end
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      scanning_in = scanning_ff;
      chunk_in    = chunk_ff;
      done_in     = 1'b0;
      found_in    = found_ff;
      slot_in     = slot_ff;
      if (ctrl.set_en) begin
         busy_in[ctrl.idx] = 1'b1;
      end
      if (ctrl.clr_en) begin
         busy_in[ctrl.idx] = 1'b0;
      end
      if (ctrl.scan_start) begin
         scanning_in = 1'b1;
         chunk_in    = '0;
      end else if (scanning_ff) begin
         if (free_any) begin
            scanning_in = 1'b0;
            done_in     = 1'b1;
            found_in    = 1'b1;
            slot_in     = SLOT_W'({chunk_ff, free_pos});
         end else if (chunk_ff == CHUNK_IDX_W'(CHUNKS - 1)) begin
            scanning_in = 1'b0;
            done_in     = 1'b1;
            found_in    = 1'b0;
            slot_in     = '0;
         end else begin
            chunk_in = chunk_ff + CHUNK_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         scanning_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         scanning_ff <= scanning_in;
         done_ff     <= done_in;
      end
      chunk_ff <= chunk_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
   end

   assign stat.done       = done_ff;
   assign stat.found      = found_ff;
   assign stat.slot       = slot_ff;
   assign stat.probe_busy = busy_ff[ctrl.idx];

   a_found_is_free: assert property (@(posedge clock) disable iff (reset)
      done_ff && found_ff |-> !busy_ff[slot_ff])
      else $error("search reported a busy slot as free");

   a_start_when_quiet: assert property (@(posedge clock) disable iff (reset)
      ctrl.scan_start |-> !scanning_ff)
      else $error("search restarted while running");

   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      $fell(scanning_ff) |-> done_ff)
      else $error("search ended without a result");

endmodule

/* hw/rtl/sorted_list_table.sv */
// ----------------------------------------------------------------------------
// sorted_list_table
// Pool of slots holding 32-bit values, linked in ascending order as a doubly
// linked list held in a value memory and a link memory.
// ----------------------------------------------------------------------------
// Use: present a request on req_* (insert, remove by value, remove by slot);
// one transaction on rsp_* answers it with status, the slot touched and the
// entry count after the request. Requests are handled one at a time:
// req_ready is high only while no request is in progress.
// Steps from acceptance to rsp_valid:
//   insert          : free-slot search (16 flags a cycle), then a walk of
//                     the list to the insertion point, then the link writes;
//                     a full table answers after the search alone
//   remove by value : a walk of the list to a match, then the unlink on a hit;
//                     a miss answers after the walk; an empty table has none
//   remove by slot  : link read, unlink; a free slot or unused code skips both
// The list walk reads one entry a cycle through the link memory's read port
// and visits at most SLOTS entries.
// A finished result sits in the output register; while rsp_ready is low the
// next request is still taken and worked, and only its hand-over waits.
// Reset empties the table at once (busy flags are flip-flops); the memories
// need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  slt_pkg::slt_req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output slt_pkg::slt_rsp_type rsp_payload
);
   import slt_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SCAN      = 4'd1;
   localparam logic [3:0] S_WALK      = 4'd2;
   localparam logic [3:0] S_RDLINK    = 4'd3;
   localparam logic [3:0] S_LINK_NEW  = 4'd4;
   localparam logic [3:0] S_LINK_PREV = 4'd5;
   localparam logic [3:0] S_LINK_NEXT = 4'd6;
   localparam logic [3:0] S_UNLINK_P  = 4'd7;
   localparam logic [3:0] S_UNLINK_N  = 4'd8;
   localparam logic [3:0] S_FIN       = 4'd9;

   logic [3:0]         state_ff, state_in;
   slt_req_type        req_ff, req_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LINK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]  prv_ff, prv_in;
   logic [LINK_W-1:0]  nxt_ff, nxt_in;
   logic [LINK_W-1:0]  steps_ff, steps_in;
   logic [SLOT_W-1:0]  tgt_ff, tgt_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   slt_rsp_type        rsp_ff, rsp_in;

   store_rd_type       rd;
   store_wr_type       wr;
   store_q_type        q;
   busy_ctrl_type      bctl;
   busy_stat_type      bstat;

   slt_store u_store (
      .clock (clock),
      .rd    (rd),
      .wr    (wr),
      .q     (q)
   );

   slt_busy u_busy (
      .clock (clock),
      .reset (reset),
      .ctrl  (bctl),
      .stat  (bstat)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      prv_in       = prv_ff;
      nxt_in       = nxt_ff;
      steps_in     = steps_ff;
      tgt_in       = tgt_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd           = '0;
      wr           = '0;
      bctl         = '0;
      bctl.idx     = tgt_ff;

      case (state_ff)
         S_IDLE: begin
            bctl.idx = req_payload.slot;
            if (req_valid) begin
               req_in    = req_payload;
               tgt_in    = '0;
               steps_in  = '0;
               status_in = STATUS_MISS;
               state_in  = S_FIN;
               case (req_payload.req_type)
                  REQ_INSERT: begin
                     bctl.scan_start = 1'b1;
                     state_in        = S_SCAN;
                  end
                  REQ_REMOVE_VALUE: begin
                     if (head_ff != NIL_LINK) begin
                        rd.en    = 1'b1;
                        rd.addr  = head_ff[SLOT_W-1:0];
                        cur_in   = head_ff;
                        state_in = S_WALK;
                     end
                  end
                  REQ_REMOVE_SLOT: begin
                     if (({1'b0, req_payload.slot} < NIL_LINK) && bstat.probe_busy) begin
                        rd.en    = 1'b1;
                        rd.addr  = req_payload.slot;
                        tgt_in   = req_payload.slot;
                        state_in = S_RDLINK;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (bstat.done) begin
               if (!bstat.found) begin
                  status_in = STATUS_FULL;
                  state_in  = S_FIN;
               end else begin
                  tgt_in = bstat.slot;
                  prv_in = NIL_LINK;
                  if (head_ff == NIL_LINK) begin
                     nxt_in   = NIL_LINK;
                     state_in = S_LINK_NEW;
                  end else begin
                     rd.en    = 1'b1;
                     rd.addr  = head_ff[SLOT_W-1:0];
                     cur_in   = head_ff;
                     state_in = S_WALK;
                  end
               end
            end
         end

         // q holds the entry at cur_ff
         S_WALK: begin
            if (req_ff.req_type == REQ_INSERT) begin
               if (steps_ff == NIL_LINK) begin
                  nxt_in   = cur_ff;
                  state_in = S_LINK_NEW;
               end else if (q.value < req_ff.value) begin
                  prv_in   = cur_ff;
                  steps_in = steps_ff + LINK_W'(1);
                  if (q.links.next < NIL_LINK) begin
                     rd.en   = 1'b1;
                     rd.addr = q.links.next[SLOT_W-1:0];
                     cur_in  = q.links.next;
                  end else begin
                     nxt_in   = NIL_LINK;
                     state_in = S_LINK_NEW;
                  end
               end else begin
                  nxt_in   = cur_ff;
                  state_in = S_LINK_NEW;
               end
            end else begin
               if (steps_ff == NIL_LINK) begin
                  state_in = S_FIN;
               end else if (q.value == req_ff.value) begin
                  tgt_in   = cur_ff[SLOT_W-1:0];
                  prv_in   = q.links.prev;
                  nxt_in   = q.links.next;
                  state_in = S_UNLINK_P;
               end else begin
                  steps_in = steps_ff + LINK_W'(1);
                  if (q.links.next < NIL_LINK) begin
                     rd.en   = 1'b1;
                     rd.addr = q.links.next[SLOT_W-1:0];
                     cur_in  = q.links.next;
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end
         end

         S_RDLINK: begin
            prv_in   = q.links.prev;
            nxt_in   = q.links.next;
            state_in = S_UNLINK_P;
         end

         S_LINK_NEW: begin
            wr.value_en = 1'b1;
            wr.prev_en  = 1'b1;
            wr.next_en  = 1'b1;
            wr.addr     = tgt_ff;
            wr.value    = req_ff.value;
            wr.prev     = prv_ff;
            wr.next     = nxt_ff;
            bctl.set_en = 1'b1;
            if (prv_ff == NIL_LINK) begin
               head_in = {1'b0, tgt_ff};
            end
            state_in = S_LINK_PREV;
         end

         S_LINK_PREV: begin
            if (prv_ff < NIL_LINK) begin
               wr.next_en = 1'b1;
               wr.addr    = prv_ff[SLOT_W-1:0];
               wr.next    = {1'b0, tgt_ff};
            end
            state_in = S_LINK_NEXT;
         end

         S_LINK_NEXT: begin
            if (nxt_ff < NIL_LINK) begin
               wr.prev_en = 1'b1;
               wr.addr    = nxt_ff[SLOT_W-1:0];
               wr.prev    = {1'b0, tgt_ff};
            end
            count_in  = count_ff + COUNT_W'(1);
            status_in = STATUS_OK;
            state_in  = S_FIN;
         end

         S_UNLINK_P: begin
            if (prv_ff < NIL_LINK) begin
               wr.next_en = 1'b1;
               wr.addr    = prv_ff[SLOT_W-1:0];
               wr.next    = nxt_ff;
            end else begin
               head_in = nxt_ff;
            end
            state_in = S_UNLINK_N;
         end

         S_UNLINK_N: begin
            if (nxt_ff < NIL_LINK) begin
               wr.prev_en = 1'b1;
               wr.addr    = nxt_ff[SLOT_W-1:0];
               wr.prev    = prv_ff;
            end
            bctl.clr_en = 1'b1;
            count_in    = count_ff - COUNT_W'(1);
            status_in   = STATUS_OK;
            state_in    = S_FIN;
         end

         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.slot_used   = (status_ff == STATUS_OK) ? tgt_ff : '0;
               rsp_in.entry_count = count_ff;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      cur_ff    <= cur_in;
      prv_ff    <= prv_in;
      nxt_ff    <= nxt_in;
      steps_ff  <= steps_in;
      tgt_ff    <= tgt_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SLOTS))
      else $error("entry count beyond pool size");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ((head_ff == NIL_LINK) == (count_ff == '0)))
      else $error("list head and entry count disagree");

   a_walk_on_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> cur_ff < NIL_LINK)
      else $error("walk visiting a null link");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_FULL |-> rsp_ff.entry_count == COUNT_W'(SLOTS))
      else $error("table full reported with free slots");

   a_result_handover: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished result not handed to output register");

endmodule
